@@ design/pfa_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfa_pkg
// Shared constants, codes and types of the page frame allocator.
// ----------------------------------------------------------------------------
package pfa_pkg;

    localparam int PAGE_COUNT      = 32768;
    localparam int PAGE_SHIFT_BITS = 12;
    localparam int REF_LIMIT       = 250;

    localparam int IDX_W     = $clog2(PAGE_COUNT);        // page index bits
    localparam int CNT_W     = IDX_W + 1;                 // holds PAGE_COUNT itself
    localparam int MAP_WORDS = (PAGE_COUNT + 31) / 32;
    localparam int WORD_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int REF_W     = 8;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int ADDR_W    = 32;

    typedef enum logic [2:0] {
        FN_ALLOC     = 3'd0,
        FN_ALLOC_DMA = 3'd1,
        FN_FREE      = 3'd2,
        FN_RESERVE   = 3'd3,
        FN_REF_GET   = 3'd4,
        FN_REF_INC   = 3'd5,
        FN_REF_DEC   = 3'd6,
        FN_NONE      = 3'd7
    } func_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_NOFREE  = 3'd1,
        ST_BADADDR = 3'd2,
        ST_SAT     = 3'd3,
        ST_UNDER   = 3'd4
    } status_t;

    localparam logic [CFG_IDX_W-1:0] REG_MANAGED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BASE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DMA     = 2'd2;

    // write side of the bitmap and count stores
    typedef struct packed {
        logic              used_we;
        logic [WORD_W-1:0] used_addr;
        logic [31:0]       used_data;
        logic              ref_we;
        logic [IDX_W-1:0]  ref_addr;
        logic [REF_W-1:0]  ref_data;
    } pfa_wr_t;

endpackage

@@ design/pfa_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfa_store
// Used-bit map and reference count memories, one write and one registered
// read port each.
// ----------------------------------------------------------------------------
module pfa_store (
    input  logic                        aclk,
    input  pfa_pkg::pfa_wr_t            wr,
    input  logic [pfa_pkg::WORD_W-1:0]  used_raddr,
    input  logic [pfa_pkg::IDX_W-1:0]   ref_raddr,
    output logic [31:0]                 used_rdata,
    output logic [pfa_pkg::REF_W-1:0]   ref_rdata
);

    logic [31:0]               used_mem [pfa_pkg::MAP_WORDS];
    logic [pfa_pkg::REF_W-1:0] ref_mem  [pfa_pkg::PAGE_COUNT];

    always_ff @(posedge aclk) begin
        if (wr.used_we) begin
            used_mem[wr.used_addr] <= wr.used_data;
        end
        used_rdata <= used_mem[used_raddr];
    end

    always_ff @(posedge aclk) begin
        if (wr.ref_we) begin
            ref_mem[wr.ref_addr] <= wr.ref_data;
        end
        ref_rdata <= ref_mem[ref_raddr];
    end

endmodule

@@ design/pfa_scan_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfa_scan_unit
// Finds the lowest free page of one bitmap word inside the window [lo, hi).
// ----------------------------------------------------------------------------
module pfa_scan_unit (
    input  logic [31:0]                word_data,
    input  logic [pfa_pkg::WORD_W-1:0] word_idx,
    input  logic [pfa_pkg::CNT_W-1:0]  lo,
    input  logic [pfa_pkg::CNT_W-1:0]  hi,
    output logic                       hit,
    output logic [4:0]                 bit_idx
);

    logic [pfa_pkg::CNT_W:0] w_base;
    logic [pfa_pkg::CNT_W:0] w_top;
    logic [31:0]             lo_mask;
    logic [31:0]             hi_mask;
    logic [31:0]             free_bits;

    always_comb begin
        w_base = (pfa_pkg::CNT_W + 1)'({word_idx, 5'b0});
        w_top  = w_base + (pfa_pkg::CNT_W + 1)'(32);
        lo_mask = ((pfa_pkg::CNT_W + 1)'(lo) <= w_base) ? '1 : ('1 << lo[4:0]);
        hi_mask = ((pfa_pkg::CNT_W + 1)'(hi) >= w_top) ? '1
                : ((32'd1 << hi[4:0]) - 32'd1);
        free_bits = ~word_data & lo_mask & hi_mask;
        hit     = |free_bits;
        bit_idx = '0;
        for (int b = 31; b >= 0; b--) begin
            if (free_bits[b]) begin
                bit_idx = 5'(b);
            end
        end
    end

endmodule

@@ design/page_frame_allocator.sv @@
`timescale 1ns / 1ps
// Ref, free and reserve results pass the states read, read-modify-write and output
//   load after the transfer; bad address, unused code and empty window go straight to it.
// Allocation reads, then checks, each scanned 32-page bitmap word (the cursor's word maybe twice).
// One request in flight: the next is taken once the result is loaded; a held result stalls.
// Reset: synchronous, active low; then a clearing pass over all PAGE_COUNT (32768)
//   pages marks every page used with count 0 before the first transfer.
// ----------------------------------------------------------------------------
// page_frame_allocator
// Physical page allocator: used-bit map, reference counts, free count and
// next-fit cursors for normal and DMA allocation.
// ----------------------------------------------------------------------------
module page_frame_allocator (
    input  logic                           aclk,
    input  logic                           aresetn,
    // request stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [39:0]                    s_tdata,   // func[2:0], page_addr[34:3]
    // result stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [63:0]                    m_tdata,   // result_addr[31:0], ref_count[39:32],
                                                      // free_pages[55:40], status[58:56]
    // configuration writes
    input  logic                           cfg_wr_en,
    input  logic [pfa_pkg::CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [pfa_pkg::CFG_W-1:0]      cfg_wr_data
);

    localparam int CNT_W = pfa_pkg::CNT_W;
    localparam int IDX_W = pfa_pkg::IDX_W;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_RD, S_MOD, S_SCAN_RD, S_SCAN_CHK, S_DONE
    } state_t;

    state_t state_reg, state_next;

    // configuration registers
    logic [pfa_pkg::CFG_W-1:0] managed_reg, base_reg, dma_lim_reg;

    // allocator state
    logic [CNT_W-1:0] free_total_reg, free_total_next;
    logic [CNT_W-1:0] norm_cur_reg, norm_cur_next;
    logic [CNT_W-1:0] dma_cur_reg, dma_cur_next;
    logic [IDX_W-1:0] clr_reg, clr_next;

    // request context
    logic [2:0]                  func_reg, func_next;
    logic [IDX_W-1:0]            idx_reg, idx_next;
    logic [pfa_pkg::WORD_W-1:0]  word_reg, word_next;
    logic [CNT_W-1:0]            lo_reg, lo_next, hi_reg, hi_next;
    logic [CNT_W-1:0]            wstart_reg, wstart_next, wend_reg, wend_next;
    logic [CNT_W-1:0]            begin_reg, begin_next;
    logic                        seg_b_reg, seg_b_next;

    // pending result
    logic [31:0]                 res_addr_reg, res_addr_next;
    logic [pfa_pkg::REF_W-1:0]   res_cnt_reg, res_cnt_next;
    pfa_pkg::status_t            res_st_reg, res_st_next;

    // output register
    logic        m_tvalid_reg, m_tvalid_next;
    logic [63:0] m_tdata_reg, m_tdata_next;

    pfa_pkg::pfa_wr_t            wr;
    logic [31:0]                 used_rdata;
    logic [pfa_pkg::REF_W-1:0]   ref_rdata;

    logic       scan_hit;
    logic [4:0] scan_bit;

    // window and address checks, evaluated at the request transfer
    logic [CNT_W-1:0]  m_eff, win_end, cur_sel, win_begin;
    logic              in_fire, is_alloc, addr_bad;
    logic [2:0]        in_func;
    logic [31:0]       in_addr;
    logic [31:0]       in_idx;

    // scan helpers
    logic [IDX_W-1:0]  found;
    logic [CNT_W:0]    found_p1, next_base;
    logic [CNT_W-1:0]  cur_after;
    logic              used_bit;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign in_fire  = s_tvalid && s_tready;
    assign in_func  = s_tdata[2:0];
    assign in_addr  = s_tdata[34:3];
    assign in_idx   = in_addr >> pfa_pkg::PAGE_SHIFT_BITS;

    pfa_store u_store (
        .aclk       (aclk),
        .wr         (wr),
        .used_raddr (word_reg),
        .ref_raddr  (idx_reg),
        .used_rdata (used_rdata),
        .ref_rdata  (ref_rdata)
    );

    pfa_scan_unit u_scan (
        .word_data (used_rdata),
        .word_idx  (word_reg),
        .lo        (lo_reg),
        .hi        (hi_reg),
        .hit       (scan_hit),
        .bit_idx   (scan_bit)
    );

    always_comb begin
        // managed count clamped to the map size
        m_eff = (CNT_W'(managed_reg) > CNT_W'(pfa_pkg::PAGE_COUNT))
              ? CNT_W'(pfa_pkg::PAGE_COUNT) : CNT_W'(managed_reg);
        is_alloc = (in_func == pfa_pkg::FN_ALLOC) || (in_func == pfa_pkg::FN_ALLOC_DMA);
        if (in_func == pfa_pkg::FN_ALLOC_DMA) begin
            win_end = (CNT_W'(dma_lim_reg) < m_eff) ? CNT_W'(dma_lim_reg) : m_eff;
            cur_sel = dma_cur_reg;
        end else begin
            win_end = m_eff;
            cur_sel = norm_cur_reg;
        end
        // cursor outside the window restarts at the window start
        win_begin = (cur_sel < CNT_W'(base_reg) || cur_sel >= win_end)
                  ? CNT_W'(base_reg) : cur_sel;
        addr_bad = (in_addr[pfa_pkg::PAGE_SHIFT_BITS-1:0] != '0)
                || (in_idx >= 32'(m_eff));
    end

    always_comb begin
        state_next      = state_reg;
        free_total_next = free_total_reg;
        norm_cur_next   = norm_cur_reg;
        dma_cur_next    = dma_cur_reg;
        clr_next        = clr_reg;
        func_next       = func_reg;
        idx_next        = idx_reg;
        word_next       = word_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        wstart_next     = wstart_reg;
        wend_next       = wend_reg;
        begin_next      = begin_reg;
        seg_b_next      = seg_b_reg;
        res_addr_next   = res_addr_reg;
        res_cnt_next    = res_cnt_reg;
        res_st_next     = res_st_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_tdata_next    = m_tdata_reg;
        wr              = '0;

        found     = {word_reg, scan_bit};
        found_p1  = (CNT_W + 1)'(found) + (CNT_W + 1)'(1);
        cur_after = (found_p1 >= (CNT_W + 1)'(wend_reg)) ? wstart_reg : found_p1[CNT_W-1:0];
        next_base = (CNT_W + 1)'({word_reg, 5'b0}) + (CNT_W + 1)'(32);
        used_bit  = used_rdata[idx_reg[4:0]];

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR: begin
                // mark every page used with count zero
                wr.used_we   = 1'b1;
                wr.used_addr = clr_reg[IDX_W-1:5];
                wr.used_data = '1;
                wr.ref_we    = 1'b1;
                wr.ref_addr  = clr_reg;
                wr.ref_data  = '0;
                clr_next     = clr_reg + 1'b1;
                if (clr_reg == IDX_W'(pfa_pkg::PAGE_COUNT - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_fire) begin
                    func_next     = in_func;
                    idx_next      = in_idx[IDX_W-1:0];
                    res_addr_next = '0;
                    res_cnt_next  = '0;
                    res_st_next   = pfa_pkg::ST_OK;
                    if (is_alloc) begin
                        wstart_next = CNT_W'(base_reg);
                        wend_next   = win_end;
                        begin_next  = win_begin;
                        lo_next     = win_begin;
                        hi_next     = win_end;
                        seg_b_next  = 1'b0;
                        word_next   = win_begin[IDX_W-1:5];
                        if (CNT_W'(base_reg) >= win_end) begin
                            res_st_next = pfa_pkg::ST_NOFREE;
                            state_next  = S_DONE;
                        end else begin
                            state_next  = S_SCAN_RD;
                        end
                    end else if (in_func == pfa_pkg::FN_NONE) begin
                        state_next = S_DONE;
                    end else if (addr_bad) begin
                        res_st_next = pfa_pkg::ST_BADADDR;
                        state_next  = S_DONE;
                    end else begin
                        word_next  = in_idx[IDX_W-1:5];
                        state_next = S_RD;
                    end
                end
            end
            S_RD: begin
                state_next = S_MOD;
            end
            S_MOD: begin
                wr.used_addr = word_reg;
                wr.ref_addr  = idx_reg;
                unique case (func_reg)
                    pfa_pkg::FN_FREE: begin
                        if (used_bit) begin
                            wr.used_we      = 1'b1;
                            wr.used_data    = used_rdata & ~(32'd1 << idx_reg[4:0]);
                            wr.ref_we       = 1'b1;
                            wr.ref_data     = '0;
                            free_total_next = free_total_reg + 1'b1;
                        end
                    end
                    pfa_pkg::FN_RESERVE: begin
                        if (!used_bit) begin
                            wr.used_we      = 1'b1;
                            wr.used_data    = used_rdata | (32'd1 << idx_reg[4:0]);
                            wr.ref_we       = 1'b1;
                            wr.ref_data     = 8'd1;
                            free_total_next = free_total_reg - 1'b1;
                            res_cnt_next    = 8'd1;
                        end else begin
                            res_cnt_next    = ref_rdata;
                        end
                    end
                    pfa_pkg::FN_REF_INC: begin
                        if (ref_rdata >= 8'(pfa_pkg::REF_LIMIT)) begin
                            res_st_next  = pfa_pkg::ST_SAT;
                            res_cnt_next = ref_rdata;
                        end else begin
                            wr.ref_we    = 1'b1;
                            wr.ref_data  = ref_rdata + 1'b1;
                            res_cnt_next = ref_rdata + 1'b1;
                        end
                    end
                    pfa_pkg::FN_REF_DEC: begin
                        if (ref_rdata == '0) begin
                            res_st_next  = pfa_pkg::ST_UNDER;
                        end else begin
                            wr.ref_we    = 1'b1;
                            wr.ref_data  = ref_rdata - 1'b1;
                            res_cnt_next = ref_rdata - 1'b1;
                        end
                    end
                    default: begin
                        res_cnt_next = ref_rdata;
                    end
                endcase
                state_next = S_DONE;
            end
            S_SCAN_RD: begin
                state_next = S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                if (scan_hit) begin
                    wr.used_we      = 1'b1;
                    wr.used_addr    = word_reg;
                    wr.used_data    = used_rdata | (32'd1 << scan_bit);
                    wr.ref_we       = 1'b1;
                    wr.ref_addr     = found;
                    wr.ref_data     = 8'd1;
                    free_total_next = free_total_reg - 1'b1;
                    if (func_reg == pfa_pkg::FN_ALLOC_DMA) begin
                        dma_cur_next  = cur_after;
                    end else begin
                        norm_cur_next = cur_after;
                    end
                    res_addr_next = 32'(32'(found) << pfa_pkg::PAGE_SHIFT_BITS);
                    res_cnt_next  = 8'd1;
                    state_next    = S_DONE;
                end else if (next_base < (CNT_W + 1)'(hi_reg)) begin
                    word_next  = word_reg + 1'b1;
                    state_next = S_SCAN_RD;
                end else if (!seg_b_reg && begin_reg != wstart_reg) begin
                    // wrap: window start up to the cursor
                    seg_b_next = 1'b1;
                    lo_next    = wstart_reg;
                    hi_next    = begin_reg;
                    word_next  = wstart_reg[IDX_W-1:5];
                    state_next = S_SCAN_RD;
                end else begin
                    res_st_next = pfa_pkg::ST_NOFREE;
                    state_next  = S_DONE;
                end
            end
            S_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {5'b0, res_st_reg, free_total_reg, res_cnt_reg,
                                     res_addr_reg};
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_CLEAR;
            managed_reg    <= 16'd32768;
            base_reg       <= 16'd256;
            dma_lim_reg    <= 16'd4096;
            free_total_reg <= '0;
            norm_cur_reg   <= '0;
            dma_cur_reg    <= CNT_W'(256);
            clr_reg        <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            free_total_reg <= free_total_next;
            norm_cur_reg   <= norm_cur_next;
            dma_cur_reg    <= dma_cur_next;
            clr_reg        <= clr_next;
            m_tvalid_reg   <= m_tvalid_next;
            if (cfg_wr_en) begin
                unique case (cfg_wr_index)
                    pfa_pkg::REG_MANAGED: managed_reg <= cfg_wr_data;
                    pfa_pkg::REG_BASE:    base_reg    <= cfg_wr_data;
                    pfa_pkg::REG_DMA:     dma_lim_reg <= cfg_wr_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        func_reg     <= func_next;
        idx_reg      <= idx_next;
        word_reg     <= word_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        wstart_reg   <= wstart_next;
        wend_reg     <= wend_next;
        begin_reg    <= begin_next;
        seg_b_reg    <= seg_b_next;
        res_addr_reg <= res_addr_next;
        res_cnt_reg  <= res_cnt_next;
        res_st_reg   <= res_st_next;
        m_tdata_reg  <= m_tdata_next;
    end

    // free count can never pass the map size
    a_free_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        free_total_reg <= CNT_W'(pfa_pkg::PAGE_COUNT))
        else $error("free page count out of range");

    // a failed allocation reports no address
    a_nofree_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[58:56] == pfa_pkg::ST_NOFREE |-> m_tdata[31:0] == '0)
        else $error("no-free result carries an address");

    // counts reported never pass the saturation limit
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[39:32] <= 8'(pfa_pkg::REF_LIMIT))
        else $error("reference count above limit");

    // no request is taken during the clearing pass
    a_clear_block: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_CLEAR |-> !s_tready)
        else $error("request taken while clearing");

endmodule
